FILE: src/fat_chain_seek_unit_defines.svh
// Assertion macros shared by the chain seek unit.
`ifndef FAT_CHAIN_SEEK_UNIT_DEFINES_SVH
`define FAT_CHAIN_SEEK_UNIT_DEFINES_SVH

`ifndef SYNTH

`define FCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define FCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: src/fcs_pkg.sv
// Types, constants and helper functions of the chain seek unit.
`default_nettype none

package fcs_pkg;

  localparam int unsigned NUM_GRANULES  = 68;
  localparam int unsigned GRANULE_BYTES = 2304;

  localparam int unsigned GRAN_W   = 7;
  localparam int unsigned ENTRY_W  = 8;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned CLAMP_W  = 18;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SECTOR_W = 4;
  localparam int unsigned SOFFS_W  = 8;
  localparam int unsigned OFFS_W   = $clog2(GRANULE_BYTES);
  localparam int unsigned COUNT_W  = $clog2(((1 << CLAMP_W) - 1) / GRANULE_BYTES + 1);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = CLAMP_W;

  localparam int unsigned DIV_SHIFT = CLAMP_W + OFFS_W;
  localparam longint unsigned DIV_RECIP = (64'd1 << DIV_SHIFT) / GRANULE_BYTES + 1;
  localparam int unsigned RECIP_W = $clog2(DIV_RECIP + 1);
  localparam int unsigned PROD_W  = CLAMP_W + RECIP_W;

  localparam logic [ENTRY_W-1:0] LAST_MARK = 8'hC0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SEEK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_GRANULE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_END     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

  typedef struct packed {
    logic               op;
    logic [GRAN_W-1:0]  table_index;
    logic [ENTRY_W-1:0] table_value;
    logic [POS_W-1:0]   position;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [GRAN_W-1:0]   granule;
    logic [SECTOR_W-1:0] sector;
    logic [SOFFS_W-1:0]  sector_offset;
    logic [CLAMP_W-1:0]  clamped_position;
  } out_t;

  typedef struct packed {
    logic               we;
    logic [GRAN_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [GRAN_W-1:0]  raddr;
  } ram_req_t;

  function automatic logic [STATUS_W-1:0] gran_class(input logic [ENTRY_W-1:0] g);
    logic [STATUS_W-1:0] c;
    if (g >= LAST_MARK) begin
      c = STATUS_END;
    end else if (g >= ENTRY_W'(NUM_GRANULES)) begin
      c = STATUS_OUTSIDE;
    end else begin
      c = STATUS_OK;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: src/fcs_gat_ram.sv
// Granule allocation table: one write port, one registered read port.
`default_nettype none

module fcs_gat_ram (
  input  wire logic                         clk_i,
  input  wire fcs_pkg::ram_req_t            req_i,
  output logic [fcs_pkg::ENTRY_W-1:0]       rd_data_o
);

  logic [fcs_pkg::ENTRY_W-1:0] mem [fcs_pkg::NUM_GRANULES];
  logic [fcs_pkg::ENTRY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: src/fcs_seek_ctrl.sv
// Sequencer that performs table writes, and clamps, divides and walks the granule chain for each seek.
`default_nettype none

module fcs_seek_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fcs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fcs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire fcs_pkg::in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output fcs_pkg::out_t                        out_data_o,
  output fcs_pkg::ram_req_t                    ram_req_o,
  input  wire logic [fcs_pkg::ENTRY_W-1:0]     ram_rd_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_REM,
    S_STEP,
    S_RESULT
  } state_e;

  state_e                         state_q, state_d;
  logic [fcs_pkg::CLAMP_W-1:0]    file_length_q, file_length_d;
  logic [fcs_pkg::GRAN_W-1:0]     first_granule_q, first_granule_d;
  logic [fcs_pkg::CLAMP_W-1:0]    clamped_q, clamped_d;
  logic [fcs_pkg::PROD_W-1:0]     prod_q, prod_d;
  logic [fcs_pkg::COUNT_W-1:0]    count_q, count_d;
  logic [fcs_pkg::OFFS_W-1:0]     offset_q, offset_d;
  logic [fcs_pkg::ENTRY_W-1:0]    gran_q, gran_d;
  logic                           use_ram_q, use_ram_d;
  fcs_pkg::out_t                  res_q, res_d;
  fcs_pkg::out_t                  out_q, out_d;
  logic                           out_valid_q, out_valid_d;

  logic                           accept;
  logic                           load_out;
  logic [fcs_pkg::ENTRY_W-1:0]    cur_gran;
  logic [fcs_pkg::STATUS_W-1:0]   cur_class;
  logic [fcs_pkg::COUNT_W-1:0]    quot;
  logic [fcs_pkg::CLAMP_W-1:0]    base;
  logic [fcs_pkg::OFFS_W-1:0]     sec_idx;

  assign accept    = in_valid_i && in_ready_o;
  assign load_out  = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);
  assign cur_gran  = use_ram_q ? ram_rd_data_i : gran_q;
  assign cur_class = fcs_pkg::gran_class(cur_gran);
  assign quot      = prod_q[fcs_pkg::DIV_SHIFT +: fcs_pkg::COUNT_W];
  assign base      = fcs_pkg::CLAMP_W'(quot) * fcs_pkg::CLAMP_W'(fcs_pkg::GRANULE_BYTES);
  assign sec_idx   = offset_q >> fcs_pkg::SOFFS_W;

  always_comb begin
    state_d         = state_q;
    file_length_d   = file_length_q;
    first_granule_d = first_granule_q;
    clamped_d       = clamped_q;
    prod_d          = prod_q;
    count_d         = count_q;
    offset_d        = offset_q;
    gran_d          = gran_q;
    use_ram_d       = use_ram_q;
    res_d           = res_q;
    out_d           = out_q;
    out_valid_d     = out_valid_q && !out_ready_i;

    ram_req_o       = '0;
    ram_req_o.waddr = in_data_i.table_index;
    ram_req_o.wdata = in_data_i.table_value;
    ram_req_o.raddr = cur_gran[fcs_pkg::GRAN_W-1:0];

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        fcs_pkg::CFG_FILE_LENGTH:   file_length_d   = cfg_data_i;
        fcs_pkg::CFG_FIRST_GRANULE: first_granule_d = cfg_data_i[fcs_pkg::GRAN_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.op == fcs_pkg::OP_WRITE) begin
            ram_req_o.we = in_data_i.table_index < fcs_pkg::GRAN_W'(fcs_pkg::NUM_GRANULES);
            res_d   = '0;
            state_d = S_RESULT;
          end else begin
            if (in_data_i.position > fcs_pkg::POS_W'(file_length_q)) begin
              clamped_d = file_length_q;
            end else begin
              clamped_d = in_data_i.position[fcs_pkg::CLAMP_W-1:0];
            end
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        prod_d  = fcs_pkg::PROD_W'(clamped_q) * fcs_pkg::PROD_W'(fcs_pkg::DIV_RECIP);
        state_d = S_REM;
      end
      S_REM: begin
        count_d   = quot;
        offset_d  = fcs_pkg::OFFS_W'(clamped_q - base);
        gran_d    = fcs_pkg::ENTRY_W'(first_granule_q);
        use_ram_d = 1'b0;
        state_d   = S_STEP;
      end
      S_STEP: begin
        if ((count_q == '0) || (cur_class != fcs_pkg::STATUS_OK)) begin
          res_d.status  = cur_class;
          res_d.granule = (cur_class == fcs_pkg::STATUS_OK) ?
                          cur_gran[fcs_pkg::GRAN_W-1:0] : '0;
          res_d.sector  = fcs_pkg::SECTOR_W'(sec_idx + fcs_pkg::OFFS_W'(1));
          res_d.sector_offset    = offset_q[fcs_pkg::SOFFS_W-1:0];
          res_d.clamped_position = clamped_q;
          state_d = S_RESULT;
        end else begin
          ram_req_o.re = 1'b1;
          count_d      = count_q - fcs_pkg::COUNT_W'(1);
          use_ram_d    = 1'b1;
        end
      end
      S_RESULT: begin
        if (load_out) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      file_length_q   <= '0;
      first_granule_q <= '0;
      out_valid_q     <= 1'b0;
      use_ram_q       <= 1'b0;
    end else begin
      state_q         <= state_d;
      file_length_q   <= file_length_d;
      first_granule_q <= first_granule_d;
      out_valid_q     <= out_valid_d;
      use_ram_q       <= use_ram_d;
    end
  end

  always_ff @(posedge clk_i) begin
    clamped_q <= clamped_d;
    prod_q    <= prod_d;
    count_q   <= count_d;
    offset_q  <= offset_d;
    gran_q    <= gran_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: src/fat_chain_seek_unit.sv
// Top level of the granule chain seek unit.
//
// The input channel (in_valid_i, in_ready_o, in_data_i) carries one transaction
// per item: a table write or a seek. The output channel (out_valid_o,
// out_ready_i, out_data_o) returns exactly one result per input transaction.
// Configuration registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i; the user must write them while the unit is idle (not enforced).
// A table write goes from acceptance straight to the result state. A seek
// clamps the position, divides it and walks at most 113 chain steps,
// reading one table entry per cycle from the single read port of the table
// memory. One transaction is processed at a time; the next one is accepted as
// soon as the current result sits in the output register.
// Reset clears the control state and the configuration registers; the table
// contents stay undefined until written. When the receiver stalls, the result
// waits in the output register and a further finished result holds the
// sequencer until the output register frees up.
`default_nettype none

`include "fat_chain_seek_unit_defines.svh"

module fat_chain_seek_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [fcs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [fcs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire fcs_pkg::in_t                    in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output fcs_pkg::out_t                        out_data_o
);

  fcs_pkg::ram_req_t            ram_req;
  logic [fcs_pkg::ENTRY_W-1:0]  ram_rd_data;

  fcs_gat_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd_data)
  );

  fcs_seek_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .ram_req_o     (ram_req),
    .ram_rd_data_i (ram_rd_data)
  );

  `FCS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
    in_valid_i && in_ready_o, !in_ready_o,
    "unit ready right after accepting a transaction")
  `FCS_ASSERT_IMPL(a_error_granule_zero, clk_i, rst_ni,
    out_valid_o && (out_data_o.status != fcs_pkg::STATUS_OK),
    out_data_o.granule == '0, "error result with nonzero granule")
  `FCS_ASSERT_IMPL(a_sector_range, clk_i, rst_ni,
    out_valid_o, out_data_o.sector <= fcs_pkg::SECTOR_W'(9), "sector beyond granule")
  `FCS_ASSERT_IMPL(a_status_code, clk_i, rst_ni, out_valid_o,
    (out_data_o.status == fcs_pkg::STATUS_OK) || (out_data_o.status == fcs_pkg::STATUS_END) ||
    (out_data_o.status == fcs_pkg::STATUS_OUTSIDE), "undefined status code")

endmodule

`default_nettype wire
